// ===== sv/blg_pkg.sv =====
// Shared constants and types for the line rasterizer.
package blg_pkg;

  // Default coordinate width and queue depth
  localparam int COORD_BITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Input item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Control bits of one classified transaction
  typedef struct packed {
    logic kind;
    logic steep;
    logic dir_neg;
  } blg_ctl_t;

  localparam int CTL_BITS = $bits(blg_ctl_t);

endpackage

// ===== sv/blg_front.sv =====
// Front end: classify input transactions and set up lines in major/minor axes.
module blg_front #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
  input  logic                                      kind,
  input  logic [COORD_BITS-1:0]                     x_start,
  input  logic [COORD_BITS-1:0]                     y_start,
  input  logic [COORD_BITS-1:0]                     x_end,
  input  logic [COORD_BITS-1:0]                     y_end,
  output logic [5*COORD_BITS+blg_pkg::CTL_BITS-1:0] entry
);
  import blg_pkg::*;

  logic [COORD_BITS-1:0] dx, dy;
  logic                  steep;
  logic [COORD_BITS-1:0] ma, na, mb, nb;
  logic [COORD_BITS-1:0] maj_lo, maj_hi, min_lo, min_hi;
  logic [COORD_BITS-1:0] major_delta, minor_delta;
  logic                  dir_neg;
  blg_ctl_t              ctl;

  // Measure extents and pick the major axis
  assign dx    = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
  assign dy    = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
  assign steep = (dy > dx);

  always_comb begin
    if (steep) begin
      ma = y_start;
      na = x_start;
      mb = y_end;
      nb = x_end;
    end else begin
      ma = x_start;
      na = y_start;
      mb = x_end;
      nb = y_end;
    end
  end

  // Order the ends so the major coordinate increases
  always_comb begin
    if (ma > mb) begin
      maj_lo = mb;
      maj_hi = ma;
      min_lo = nb;
      min_hi = na;
    end else begin
      maj_lo = ma;
      maj_hi = mb;
      min_lo = na;
      min_hi = nb;
    end
  end

  assign major_delta = maj_hi - maj_lo;
  assign minor_delta = (min_lo > min_hi) ? (min_lo - min_hi) : (min_hi - min_lo);
  assign dir_neg     = !(min_lo < min_hi);

  assign ctl.kind    = kind;
  assign ctl.steep   = steep;
  assign ctl.dir_neg = dir_neg;

  // Pack the classified transaction for the queue
  assign entry = {ctl, maj_lo, maj_hi, min_lo, major_delta, minor_delta};

endmodule

// ===== sv/blg_queue.sv =====
// Short FIFO that decouples the front end from the stepper.
module blg_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = blg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);
  import blg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wptr_r, wptr_nxt;
  logic [PW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rptr_r];

  // Advance pointers with explicit wrap
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== sv/blg_back.sv =====
// Back end: step the active line one pixel per transaction and hold the result.
module blg_back #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      q_empty,
  input  logic [5*COORD_BITS+blg_pkg::CTL_BITS-1:0] q_data,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_point_valid,
  output logic [COORD_BITS-1:0]                     out_point_x,
  output logic [COORD_BITS-1:0]                     out_point_y,
  output logic                                      out_last_point,
  output logic                                      out_idle
);
  import blg_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 2;

  // Unpacked queue entry
  blg_ctl_t        e_ctl;
  logic [CB-1:0]   e_major_pos, e_major_stop, e_minor_pos, e_major_delta, e_minor_delta;

  // Line state
  logic            active_r, active_nxt;
  logic            steep_r, steep_nxt;
  logic [CB-1:0]   major_pos_r, major_pos_nxt;
  logic [CB-1:0]   major_stop_r, major_stop_nxt;
  logic [CB-1:0]   minor_pos_r, minor_pos_nxt;
  logic [CB-1:0]   major_delta_r, major_delta_nxt;
  logic [CB-1:0]   minor_delta_r, minor_delta_nxt;
  logic            dir_neg_r, dir_neg_nxt;
  logic [EW-1:0]   err_r, err_nxt;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  logic            pv_r, pv_nxt;
  logic [CB-1:0]   px_r, px_nxt;
  logic [CB-1:0]   py_r, py_nxt;
  logic            last_r, last_nxt;
  logic            idle_r, idle_nxt;

  logic [EW-1:0]   err_sub;
  logic [CB-1:0]   major_inc;

  assign {e_ctl, e_major_pos, e_major_stop, e_minor_pos, e_major_delta, e_minor_delta} = q_data;

  // Take a transaction whenever the output register is free or draining
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  assign err_sub   = err_r - {2'b00, minor_delta_r};
  assign major_inc = major_pos_r + 1'b1;

  always_comb begin
    active_nxt      = active_r;
    steep_nxt       = steep_r;
    major_pos_nxt   = major_pos_r;
    major_stop_nxt  = major_stop_r;
    minor_pos_nxt   = minor_pos_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    dir_neg_nxt     = dir_neg_r;
    err_nxt         = err_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    pv_nxt          = pv_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    last_nxt        = last_r;
    idle_nxt        = idle_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      pv_nxt        = 1'b0;
      px_nxt        = '0;
      py_nxt        = '0;
      last_nxt      = 1'b0;
      if (e_ctl.kind == KIND_START) begin
        // Load a new line, dropping any line in progress
        steep_nxt       = e_ctl.steep;
        dir_neg_nxt     = e_ctl.dir_neg;
        major_pos_nxt   = e_major_pos;
        major_stop_nxt  = e_major_stop;
        minor_pos_nxt   = e_minor_pos;
        major_delta_nxt = e_major_delta;
        minor_delta_nxt = e_minor_delta;
        err_nxt         = {3'b000, e_major_delta[CB-1:1]};
        active_nxt      = (e_major_delta != '0);
        idle_nxt        = (e_major_delta == '0);
      end else if (active_r) begin
        // Emit the current pixel and advance one step
        pv_nxt = 1'b1;
        px_nxt = steep_r ? minor_pos_r : major_pos_r;
        py_nxt = steep_r ? major_pos_r : minor_pos_r;
        if (err_sub[EW-1]) begin
          minor_pos_nxt = dir_neg_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
          err_nxt       = err_sub + {2'b00, major_delta_r};
        end else begin
          err_nxt = err_sub;
        end
        major_pos_nxt = major_inc;
        if (major_inc == major_stop_r) begin
          last_nxt   = 1'b1;
          active_nxt = 1'b0;
        end
        idle_nxt = (major_inc == major_stop_r);
      end else begin
        idle_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      steep_r       <= 1'b0;
      major_pos_r   <= '0;
      major_stop_r  <= '0;
      minor_pos_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      dir_neg_r     <= 1'b0;
      err_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      active_r      <= active_nxt;
      steep_r       <= steep_nxt;
      major_pos_r   <= major_pos_nxt;
      major_stop_r  <= major_stop_nxt;
      minor_pos_r   <= minor_pos_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      dir_neg_r     <= dir_neg_nxt;
      err_r         <= err_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pv_r   <= pv_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    idle_r <= idle_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_point_valid = pv_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_last_point  = last_r;
  assign out_idle        = idle_r;

  a_active_span: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (major_pos_r != major_stop_r))
    else $error("active line already at its stop");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (idle_r && pv_r && !active_r))
    else $error("last pixel without going idle");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pv_r) |-> (px_r == '0 && py_r == '0 && !last_r))
    else $error("pixel-free result carries data");

  a_pixel_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && e_ctl.kind == KIND_ADVANCE && !active_r) |=> !pv_r)
    else $error("pixel emitted with no active line");

endmodule

// ===== sv/bresenham_line_generator.sv =====
// Bresenham line rasterizer: front end, transaction queue and pixel stepper.
// A transaction is written into the queue, then popped by the stepper into its output register;
//   queued transactions wait their turn behind earlier ones.
// Throughput: one transaction per cycle unless out_ready stalls the output register, set by
//   the stepper's single subtract-compare-add error update per pixel.
// Reset (synchronous, active low) clears the queue, the output valid flag and the line state; the payload is not reset.
module bresenham_line_generator #(
  parameter int COORD_BITS  = blg_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = blg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_x_start,
  input  logic [COORD_BITS-1:0] in_y_start,
  input  logic [COORD_BITS-1:0] in_x_end,
  input  logic [COORD_BITS-1:0] in_y_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_point_valid,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic                  out_last_point,
  output logic                  out_idle
);
  import blg_pkg::*;

  localparam int ENTRY_W = 5 * COORD_BITS + CTL_BITS;

  logic [ENTRY_W-1:0] f_entry;
  logic [ENTRY_W-1:0] q_data;
  logic               q_full, q_empty, q_pop, q_push;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  blg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .kind    (in_kind),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .entry   (f_entry)
  );

  blg_queue #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  blg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last_point  (out_last_point),
    .out_idle        (out_idle)
  );

endmodule

// ===== tb/sv/bresenham_line_generator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Bresenham line rasterizer with a pixel scoreboard.
module bresenham_line_generator_tb;
  import blg_pkg::*;

  localparam int CW        = COORD_BITS_DEF;
  localparam int ITEM_GOAL = 950;
  localparam int MAX_CYCLES = 200_000;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    logic   point_valid;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
    logic   idle;
  } pixel_res_t;

  // Track the line state and the queue of pixels still owed by the block
  class line_scoreboard;
    pixel_res_t              pixel_q[$];
    int                      errors;
    logic                    active;
    logic                    steep;
    coord_t                  major_pos;
    coord_t                  major_stop;
    coord_t                  minor_pos;
    coord_t                  major_delta;
    coord_t                  minor_delta;
    logic                    minor_dir_neg;
    logic signed [CW+1:0]    err_acc;

    function new();
      errors        = 0;
      active        = 1'b0;
      steep         = 1'b0;
      major_pos     = '0;
      major_stop    = '0;
      minor_pos     = '0;
      major_delta   = '0;
      minor_delta   = '0;
      minor_dir_neg = 1'b0;
      err_acc       = '0;
    endfunction

    function coord_t span(coord_t a, coord_t b);
      return (a > b) ? a - b : b - a;
    endfunction

    function logic line_active();
      return active;
    endfunction

    function int steps_left();
      return active ? int'(coord_t'(major_stop - major_pos)) : 0;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // Advance the line state for one accepted transaction and queue its pixel
    function void note_item(logic kind, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
      pixel_res_t r;
      coord_t     ma, na, mb, nb, t;
      r = '0;
      if (kind == KIND_START) begin
        steep = span(ys, ye) > span(xs, xe);
        if (steep) begin
          ma = ys; na = xs; mb = ye; nb = xe;
        end else begin
          ma = xs; na = ys; mb = xe; nb = ye;
        end
        // order the ends so the major coordinate increases
        if (ma > mb) begin
          t = ma; ma = mb; mb = t;
          t = na; na = nb; nb = t;
        end
        major_pos     = ma;
        major_stop    = mb;
        minor_pos     = na;
        major_delta   = mb - ma;
        minor_delta   = span(na, nb);
        minor_dir_neg = !(na < nb);
        err_acc       = $signed({2'b00, coord_t'(major_delta >> 1)});
        active        = (major_delta != '0);
      end else if (active) begin
        r.point_valid = 1'b1;
        r.point_x     = steep ? minor_pos : major_pos;
        r.point_y     = steep ? major_pos : minor_pos;
        err_acc = err_acc - $signed({2'b00, minor_delta});
        if (err_acc < 0) begin
          minor_pos = minor_dir_neg ? minor_pos - 1'b1 : minor_pos + 1'b1;
          err_acc   = err_acc + $signed({2'b00, major_delta});
        end
        major_pos = major_pos + 1'b1;
        if (major_pos == major_stop) begin
          r.last_point = 1'b1;
          active       = 1'b0;
        end
      end
      r.idle = !active;
      pixel_q.push_back(r);
    endfunction

    // Compare one delivered pixel against the oldest queued one
    function void check_pixel(pixel_res_t got);
      pixel_res_t want;
      if (pixel_q.size() == 0) begin
        $error("pixel transaction arrived with nothing outstanding");
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      if (got.point_valid !== want.point_valid) begin
        $error("point_valid expected %0d actual %0d", want.point_valid, got.point_valid);
        errors++;
      end
      if (got.point_x !== want.point_x) begin
        $error("point_x expected %0d actual %0d", want.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y expected %0d actual %0d", want.point_y, got.point_y);
        errors++;
      end
      if (got.last_point !== want.last_point) begin
        $error("last_point expected %0d actual %0d", want.last_point, got.last_point);
        errors++;
      end
      if (got.idle !== want.idle) begin
        $error("idle expected %0d actual %0d", want.idle, got.idle);
        errors++;
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_kind;
  coord_t in_x_start;
  coord_t in_y_start;
  coord_t in_x_end;
  coord_t in_y_end;
  logic   out_valid;
  logic   out_ready;
  logic   out_point_valid;
  coord_t out_point_x;
  coord_t out_point_y;
  logic   out_last_point;
  logic   out_idle;

  line_scoreboard sb = new();
  int             issued = 0;
  int             cycles = 0;
  logic           quiet = 1'b0;

  bresenham_line_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_valid (out_point_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_last_point  (out_last_point),
    .out_idle        (out_idle)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $error("run timed out with %0d pixels outstanding", sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Check delivered pixels and stall the result side at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_pixel('{out_point_valid, out_point_x, out_point_y, out_last_point, out_idle});
    end
    out_ready <= quiet || ($urandom_range(99) >= 17);
  end

  // Drive one transaction, idling at random first; leave valid high after acceptance
  task automatic send_item(input logic kind, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_START || sb.line_active()) issued++;
    sb.note_item(kind, xs, ys, xe, ye);
  endtask

  task automatic start_line(input coord_t xs, input coord_t ys, input coord_t xe,
                            input coord_t ye);
    send_item(KIND_START, xs, ys, xe, ye);
  endtask

  // Advance with junk endpoint fields, which the block ignores
  task automatic advance_line(input int n);
    repeat (n) send_item(KIND_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom));
  endtask

  // Hold the sender until every outstanding pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic coord_t near_coord(input coord_t base);
    int v;
    v = int'(base) + int'($urandom_range(48)) - 24;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return coord_t'(v);
  endfunction

  initial begin
    int     r;
    int     n;
    logic   drained;
    coord_t xs, ys, xe, ye;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_START;
    in_x_start = '0;
    in_y_start = '0;
    in_x_end   = '0;
    in_y_end   = '0;
    out_ready  = 1'b0;
    drained    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: advance while idle, zero-length line
    advance_line(1);
    start_line(10'd5, 10'd5, 10'd5, 10'd5);
    advance_line(1);
    // Full-range diagonals, the first abandoned by the second
    start_line(10'd1023, 10'd1023, 10'd0, 10'd0);
    advance_line(2);
    start_line(10'd0, 10'd1023, 10'd1023, 10'd0);
    advance_line(1);
    // Shallow line with equal minor ends, reversed; run past its end
    start_line(10'd3, 10'd7, 10'd0, 10'd7);
    advance_line(4);
    // Steep line with positive minor step, run to the end
    start_line(10'd10, 10'd20, 10'd8, 10'd15);
    advance_line(5);
    // Vertical line touching the top edge, abandoned midway
    start_line(10'd1023, 10'd1021, 10'd1023, 10'd1023);
    advance_line(1);
    start_line(10'd0, 10'd0, 10'd2, 10'd1);
    advance_line(2);
    drain();

    // Random lines, mostly short and run to their end
    while (issued < ITEM_GOAL) begin
      if (!drained && issued >= 500) begin
        drain();
        drained = 1'b1;
      end
      quiet = (issued >= 250 && issued < 400);
      r = $urandom_range(99);
      if (r < 4) begin
        advance_line(1);
      end else begin
        xs = coord_t'($urandom);
        ys = coord_t'($urandom);
        if (r < 8) begin
          xe = coord_t'($urandom);
          ye = coord_t'($urandom);
        end else begin
          xe = near_coord(xs);
          ye = near_coord(ys);
        end
        start_line(xs, ys, xe, ye);
        n = sb.steps_left();
        if ($urandom_range(9) < 2) begin
          n = $urandom_range(n);
        end else if ($urandom_range(9) == 0) begin
          n = n + $urandom_range(1, 2);
        end
        if (n > 300) n = $urandom_range(16, 64);
        advance_line(n);
      end
    end
    quiet = 1'b0;

    // Wait out the remaining pixels and any stray ones
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
